// ===== src/dq_pkg.sv =====
// ----------------------------------------------------------------------------
// Deque package
// Shared constants, codes, item types and byte mask helper for the deque.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DEPTH_DEFAULT      = 16;
  localparam int DATA_BYTES_DEFAULT = 8;

  // widest ring address over the supported depth range (up to 4096)
  localparam int ADDR_W_MAX = 12;

  // depth of the queue between front and back
  localparam int OP_QUEUE_DEPTH = 2;

  localparam logic [3:0] ELEMENT_BYTES_RESET = 4'd8;

  // commands
  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_PEEK_FRONT = 3'd4;
  localparam logic [2:0] CMD_PEEK_BACK  = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_LENGTH = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [3:0]  length_bytes;
    logic [63:0] data_in;
    logic [3:0]  peek_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] data_out;
    logic [4:0]  occupancy;
  } rsp_t;

  // classified command handed from front to back
  typedef struct packed {
    logic                  wr;
    logic                  rd;
    logic [ADDR_W_MAX-1:0] addr;
    logic [63:0]           wdata;
    logic [3:0]            rbytes;
    logic [1:0]            status;
    logic [4:0]            occupancy;
  } op_t;

  // keep the low n bytes, n of eight or more keeps all
  function automatic logic [63:0] byte_mask(input logic [3:0] n);
    logic [63:0] m;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// ===== src/double_ended_queue.sv =====
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of DEPTH elements with push, pop and peek at either end.
// ----------------------------------------------------------------------------
// Each request item carries one command (push or pop at the front or back,
// or a peek at an offset from either end) and yields exactly one response
// item with a status, the data and the occupancy after the command. The
// block sustains one item per clock unless responses stall: the front end
// keeps the front position and element count, and the back end drives one
// access per cycle to the ring store. A response passes the operation queue,
// the store access stage and the response register. The front and back are
// joined by a two-entry queue, which a stalled response side fills before
// the request side stalls. The user must write element_bytes through
// cfg_we/cfg_data only while the block is idle; the block does not enforce
// it. The store is not cleared at reset; only written slots are ever read.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
  parameter int DATA_BYTES = dq_pkg::DATA_BYTES_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  // element size register
  input  logic         cfg_we,
  input  logic [3:0]   cfg_data,
  // request channel
  input  logic         req_valid,
  output logic         req_ready,
  input  dq_pkg::req_t req,
  // response channel
  output logic         rsp_valid,
  input  logic         rsp_ready,
  output dq_pkg::rsp_t rsp
);
  import dq_pkg::*;

  // classified item from the front end
  logic front_valid, front_ready;
  op_t  front_op;

  // head of the operation queue
  logic back_valid, back_ready;
  op_t  back_op;

  dq_front #(
    .DEPTH      (DEPTH),
    .DATA_BYTES (DATA_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .op_valid  (front_valid),
    .op_ready  (front_ready),
    .op        (front_op)
  );

  dq_op_fifo u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_op    (front_op),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_op     (back_op)
  );

  // store access and response register
  dq_back #(
    .DEPTH      (DEPTH),
    .DATA_BYTES (DATA_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (back_valid),
    .op_ready  (back_ready),
    .op        (back_op),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== src/dq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/dq_front.sv =====
// ----------------------------------------------------------------------------
// Deque front end
// Accepts items, runs the checks, tracks front position and count, and
// emits one classified operation per item.
// ----------------------------------------------------------------------------
module dq_front #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
  parameter int DATA_BYTES = dq_pkg::DATA_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_data,
  input  logic        req_valid,
  output logic        req_ready,
  input  dq_pkg::req_t req,
  output logic        op_valid,
  input  logic        op_ready,
  output dq_pkg::op_t op
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int OW = (CW > 4) ? CW : 4;

  logic [3:0]    element_bytes;
  logic [AW-1:0] front_pos, front_pos_next;
  logic [CW-1:0] count, count_next;

  logic [3:0]    eff_bytes;
  logic          len_bad, is_empty, is_full, off_bad;
  logic [CW-1:0] slot_dist;
  logic [CW:0]   sum;
  logic [AW-1:0] slot, front_inc, front_dec;
  logic          accept;

  assign req_ready = op_ready;
  assign op_valid  = req_valid;
  assign accept    = req_valid && req_ready;

  assign eff_bytes = (element_bytes > 4'(DATA_BYTES)) ? 4'(DATA_BYTES) : element_bytes;
  assign len_bad   = req.length_bytes > eff_bytes;
  assign is_empty  = (count == '0);
  assign is_full   = (count >= CW'(DEPTH));
  assign off_bad   = OW'(req.peek_offset) >= OW'(count);

  assign front_inc = (front_pos == AW'(DEPTH - 1)) ? '0 : front_pos + AW'(1);
  assign front_dec = (front_pos == '0) ? AW'(DEPTH - 1) : front_pos - AW'(1);

  // distance from the front for the slot that the command touches
  always_comb begin
    case (req.command)
      CMD_PUSH_BACK:  slot_dist = count;
      CMD_POP_BACK:   slot_dist = count - CW'(1);
      CMD_PEEK_FRONT: slot_dist = CW'(req.peek_offset);
      CMD_PEEK_BACK:  slot_dist = count - CW'(1) - CW'(req.peek_offset);
      default:        slot_dist = '0;
    endcase
  end

  // ring add, one wrap at most
  assign sum  = (CW+1)'(front_pos) + (CW+1)'(slot_dist);
  assign slot = (sum >= (CW+1)'(DEPTH)) ? AW'(sum - (CW+1)'(DEPTH)) : AW'(sum);

  always_comb begin
    count_next     = count;
    front_pos_next = front_pos;
    op             = '0;
    op.status      = ST_OK;
    op.wdata       = req.data_in & byte_mask(req.length_bytes);
    op.rbytes      = req.length_bytes;
    unique case (req.command) inside
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (len_bad) begin
          op.status = ST_LENGTH;
        end else if (is_full) begin
          op.status = ST_FULL;
        end else begin
          op.wr      = 1'b1;
          count_next = count + CW'(1);
          if (req.command == CMD_PUSH_FRONT) begin
            front_pos_next = front_dec;
            op.addr        = ADDR_W_MAX'(front_dec);
          end else begin
            op.addr = ADDR_W_MAX'(slot);
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (is_empty) begin
          op.status = ST_EMPTY;
        end else if (len_bad) begin
          op.status = ST_LENGTH;
        end else begin
          op.rd      = 1'b1;
          count_next = count - CW'(1);
          if (req.command == CMD_POP_FRONT) begin
            front_pos_next = front_inc;
            op.addr        = ADDR_W_MAX'(front_pos);
          end else begin
            op.addr = ADDR_W_MAX'(slot);
          end
        end
      end
      CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
        if (off_bad) begin
          op.status = ST_EMPTY;
        end else begin
          op.rd     = 1'b1;
          op.addr   = ADDR_W_MAX'(slot);
          op.rbytes = 4'(DATA_BYTES);
        end
      end
      default: begin
        op.status = ST_EMPTY;
      end
    endcase
    op.occupancy = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_bytes <= ELEMENT_BYTES_RESET;
      front_pos     <= '0;
      count         <= '0;
    end else begin
      if (cfg_we) begin
        element_bytes <= cfg_data;
      end
      if (accept) begin
        front_pos <= front_pos_next;
        count     <= count_next;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count above depth");

  a_front_bound: assert property (@(posedge clk) disable iff (rst)
    (CW+1)'(front_pos) < (CW+1)'(DEPTH))
    else $error("front position outside ring");

endmodule

// ===== src/dq_op_fifo.sv =====
// ----------------------------------------------------------------------------
// Operation queue
// Short register queue between the front and back ends.
// ----------------------------------------------------------------------------
module dq_op_fifo (
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  output logic        push_ready,
  input  dq_pkg::op_t push_op,
  output logic        pop_valid,
  input  logic        pop_ready,
  output dq_pkg::op_t pop_op
);
  import dq_pkg::*;

  localparam int QAW = $clog2(OP_QUEUE_DEPTH);

  op_t          entries [OP_QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   fill;
  logic           do_push, do_pop;

  assign push_ready = (fill != (QAW+1)'(OP_QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_op     = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + (QAW+1)'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - (QAW+1)'(1);
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (QAW+1)'(OP_QUEUE_DEPTH))
    else $error("operation queue overfilled");

endmodule

// ===== src/dq_back.sv =====
// ----------------------------------------------------------------------------
// Deque back end
// Carries out store writes and reads and registers the result item.
// ----------------------------------------------------------------------------
module dq_back #(
  parameter int DEPTH      = dq_pkg::DEPTH_DEFAULT,
  parameter int DATA_BYTES = dq_pkg::DATA_BYTES_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         op_valid,
  output logic         op_ready,
  input  dq_pkg::op_t  op,
  output logic         rsp_valid,
  input  logic         rsp_ready,
  output dq_pkg::rsp_t rsp
);
  import dq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int DW = 8 * DATA_BYTES;

  logic          s1_valid, s1_rd;
  logic [3:0]    s1_rbytes;
  logic [1:0]    s1_status;
  logic [4:0]    s1_occ;
  logic [DW-1:0] ram_rdata;
  logic          out_free, s1_adv, take;

  assign out_free = !rsp_valid || rsp_ready;
  assign s1_adv   = s1_valid && out_free;
  assign op_ready = !s1_valid || out_free;
  assign take     = op_valid && op_ready;

  dq_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (take && op.wr),
    .waddr (op.addr[AW-1:0]),
    .wdata (op.wdata[DW-1:0]),
    .re    (take && op.rd),
    .raddr (op.addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (take) begin
      s1_rd     <= op.rd;
      s1_rbytes <= op.rbytes;
      s1_status <= op.status;
      s1_occ    <= op.occupancy;
    end
    if (s1_adv) begin
      rsp.status    <= s1_status;
      rsp.data_out  <= s1_rd ? (64'(ram_rdata) & byte_mask(s1_rbytes)) : '0;
      rsp.occupancy <= s1_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (out_free) begin
        rsp_valid <= s1_valid;
      end
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> rsp.data_out == '0)
    else $error("failed item carries data");

  a_hold_read: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> $stable(ram_rdata))
    else $error("read data lost while result stalled");

endmodule

// ===== test/tb_double_ended_queue.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Sends push, pop and peek items with random gaps and response stalls. Each
// accepted item is run through a local copy of the deque and its response is
// predicted, then checked field by field against what the block returns. The
// element size register is changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;
  import dq_pkg::*;

  localparam int RING_SLOTS     = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 135;
  localparam int MAX_PRINTED    = 40;

  // command codes the block does not define; they must leave the deque unchanged
  localparam logic [2:0] CMD_UNDEF_LO = 3'd6;
  localparam logic [2:0] CMD_UNDEF_HI = 3'd7;

  // shape of a run of random items
  typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} burst_mode_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       cfg_we    = 1'b0;
  logic [3:0] cfg_data  = 4'd0;
  logic       req_valid = 1'b0;
  logic       req_ready;
  req_t       req       = '0;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  rsp_t       rsp;

  // items waiting to be sent, and responses owed by the block in order
  req_t requests_to_send[$];
  rsp_t due_responses[$];

  // local copy of the deque state and the element size register
  logic [63:0] ring_data[RING_SLOTS];
  logic [3:0]  ring_front     = 4'd0;
  logic [4:0]  ring_count     = 5'd0;
  logic [3:0]  elem_bytes_cfg = ELEMENT_BYTES_RESET;

  // sender and receiver pacing
  int send_wait    = 0;
  int send_stretch = 0;
  bit send_calm    = 1'b0;
  int recv_wait    = 0;
  int recv_stretch = 0;
  bit recv_calm    = 1'b0;

  int mismatches     = 0;
  int responses_seen = 0;
  int idle_cycles    = 0;

  double_ended_queue i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // low n bytes set; eight or more keeps the whole word
  function automatic logic [63:0] keep_low_bytes(input logic [3:0] n);
    if (n >= 4'd8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  // applies one item to the local deque and returns the response it earns
  function automatic rsp_t deque_apply(input req_t r);
    rsp_t       o;
    logic [3:0] size_limit;
    logic [3:0] slot;
    o          = '0;
    o.status   = ST_OK;
    // register values above the word width act as the full word
    size_limit = (elem_bytes_cfg > 4'd8) ? 4'd8 : elem_bytes_cfg;
    case (r.command)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        // length refusal wins over a full ring
        if (r.length_bytes > size_limit) begin
          o.status = ST_LENGTH;
        end else if (ring_count >= 5'(RING_SLOTS)) begin
          o.status = ST_FULL;
        end else begin
          if (r.command == CMD_PUSH_FRONT) begin
            ring_front = ring_front - 4'd1;
            slot       = ring_front;
          end else begin
            slot = ring_front + ring_count[3:0];
          end
          ring_data[slot] = r.data_in & keep_low_bytes(r.length_bytes);
          ring_count      = ring_count + 5'd1;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        // empty wins over a length refusal
        if (ring_count == 5'd0) begin
          o.status = ST_EMPTY;
        end else if (r.length_bytes > size_limit) begin
          o.status = ST_LENGTH;
        end else begin
          if (r.command == CMD_POP_FRONT) begin
            slot       = ring_front;
            ring_front = ring_front + 4'd1;
          end else begin
            slot = ring_front + ring_count[3:0] - 4'd1;
          end
          o.data_out = ring_data[slot] & keep_low_bytes(r.length_bytes);
          ring_count = ring_count - 5'd1;
        end
      end
      CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
        if ({1'b0, r.peek_offset} >= ring_count) begin
          o.status = ST_EMPTY;
        end else begin
          if (r.command == CMD_PEEK_FRONT) slot = ring_front + r.peek_offset;
          else slot = ring_front + ring_count[3:0] - 4'd1 - r.peek_offset;
          o.data_out = ring_data[slot];
        end
      end
      default: o.status = ST_EMPTY;
    endcase
    o.occupancy = ring_count;
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: takes items from the send queue, random gap before each item
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        due_responses.push_back(deque_apply(req));
        // now and then a stretch with no gaps at all
        if (send_stretch == 0) begin
          send_stretch = $urandom_range(20, 60);
          send_calm    = ($urandom_range(0, 3) == 0);
        end
        send_stretch--;
        send_wait = send_calm ? 0 : $urandom_range(0, 3);
      end
      if (req_valid && !req_ready) begin
        // hold the item until it is taken
      end else if (send_wait > 0) begin
        req_valid <= 1'b0;
        send_wait--;
      end else if (requests_to_send.size() != 0) begin
        req       <= requests_to_send.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each response item, random stall after each one
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("mismatch at response %0d, %s: got %0h, expected %0h",
               responses_seen, what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (due_responses.size() == 0) begin
          report_mismatch("response with none due", rsp.data_out, 64'd0);
        end else begin
          rsp_t want;
          want = due_responses.pop_front();
          if (rsp.status !== want.status)
            report_mismatch("status", 64'(rsp.status), 64'(want.status));
          if (rsp.data_out !== want.data_out)
            report_mismatch("data_out", rsp.data_out, want.data_out);
          if (rsp.occupancy !== want.occupancy)
            report_mismatch("occupancy", 64'(rsp.occupancy), 64'(want.occupancy));
        end
        responses_seen++;
        if (recv_stretch == 0) begin
          recv_stretch = $urandom_range(20, 60);
          recv_calm    = ($urandom_range(0, 3) == 0);
        end
        recv_stretch--;
        recv_wait = recv_calm ? 0 : $urandom_range(0, 3);
      end
      if (recv_wait > 0) begin
        rsp_ready <= 1'b0;
        recv_wait--;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // watchdog: too long with no item moving on either side
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic req_t make_req(input logic [2:0] cmd, input logic [3:0] len,
                                    input logic [63:0] data, input logic [3:0] off);
    req_t r;
    r.command      = cmd;
    r.length_bytes = len;
    r.data_in      = data;
    r.peek_offset  = off;
    return r;
  endfunction

  function automatic req_t random_request(input burst_mode_t mode, input int lim);
    req_t r;
    int   pick;
    int   push_pct;
    int   pop_pct;
    case (mode)
      MODE_FILL:  begin push_pct = 70; pop_pct = 5;  end
      MODE_DRAIN: begin push_pct = 10; pop_pct = 65; end
      default:    begin push_pct = 35; pop_pct = 35; end
    endcase
    pick = $urandom_range(0, 99);
    if (pick < push_pct)
      r.command = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    else if (pick < push_pct + pop_pct)
      r.command = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
    else if (pick < 97)
      r.command = $urandom_range(0, 1) ? CMD_PEEK_BACK : CMD_PEEK_FRONT;
    else
      r.command = $urandom_range(0, 1) ? CMD_UNDEF_HI : CMD_UNDEF_LO;
    // mostly lengths the current size allows, some that it refuses
    r.length_bytes = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(0, lim))
                                                 : 4'($urandom_range(0, 8));
    r.data_in      = ($urandom_range(0, 9) == 0) ? '1 : {$urandom, $urandom};
    r.peek_offset  = $urandom_range(0, 1) ? 4'($urandom_range(0, 3))
                                          : 4'($urandom_range(0, 15));
    return r;
  endfunction

  // nothing queued, nothing on the request port, nothing owed
  task automatic wait_idle;
    @(negedge clk);
    while (requests_to_send.size() != 0 || req_valid || due_responses.size() != 0)
      @(negedge clk);
  endtask

  // register write only once the block has gone quiet
  task automatic write_elem_bytes(input logic [3:0] value);
    wait_idle();
    repeat (3) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we         <= 1'b0;
    elem_bytes_cfg = value;
  endtask

  // random runs of fill, drain and mixed items
  task automatic random_phase(input logic [3:0] setting, input int count);
    int          produced;
    int          burst;
    int          lim;
    burst_mode_t mode;
    produced = 0;
    lim      = (setting > 4'd8) ? 8 : int'(setting);
    while (produced < count) begin
      mode  = burst_mode_t'($urandom_range(0, 2));
      burst = $urandom_range(8, 30);
      for (int i = 0; i < burst && produced < count; i++) begin
        requests_to_send.push_back(random_request(mode, lim));
        produced++;
      end
    end
  endtask

  initial begin
    logic [3:0] settings[8];
    settings = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd4, 4'd0, 4'd0, 4'd0};
    for (int i = 5; i < 8; i++) settings[i] = 4'($urandom_range(0, 15));

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_elem_bytes(settings[0]);

    // directed: empty ring, unknown commands, zero length, fill to full
    requests_to_send.push_back(make_req(CMD_POP_FRONT, 4'd0, '1, 4'd0));
    requests_to_send.push_back(make_req(CMD_POP_BACK, 4'd8, '1, 4'd0));
    requests_to_send.push_back(make_req(CMD_PEEK_FRONT, 4'd0, '0, 4'd0));
    requests_to_send.push_back(make_req(CMD_PEEK_BACK, 4'd0, '0, 4'd15));
    requests_to_send.push_back(make_req(CMD_UNDEF_LO, 4'd8, '1, 4'd0));
    requests_to_send.push_back(make_req(CMD_UNDEF_HI, 4'd0, '1, 4'd15));
    requests_to_send.push_back(make_req(CMD_PUSH_BACK, 4'd8, '1, 4'd0));
    // zero length stores a zero element
    requests_to_send.push_back(make_req(CMD_PUSH_FRONT, 4'd0, '1, 4'd0));
    requests_to_send.push_back(make_req(CMD_PUSH_BACK, 4'd1, 64'h0123_4567_89ab_cdef, 4'd0));
    requests_to_send.push_back(make_req(CMD_PUSH_FRONT, 4'd8, '0, 4'd0));
    requests_to_send.push_back(make_req(CMD_PEEK_FRONT, 4'd0, '0, 4'd0));
    // offset equal to occupancy is out of range
    requests_to_send.push_back(make_req(CMD_PEEK_FRONT, 4'd0, '0, 4'd4));
    for (int i = 0; i < 12; i++)
      requests_to_send.push_back(make_req(i[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                                          4'd8, {$urandom, $urandom}, 4'd0));
    requests_to_send.push_back(make_req(CMD_PUSH_BACK, 4'd8, '1, 4'd0));
    requests_to_send.push_back(make_req(CMD_PEEK_BACK, 4'd0, '0, 4'd15));
    requests_to_send.push_back(make_req(CMD_POP_FRONT, 4'd8, '0, 4'd0));
    requests_to_send.push_back(make_req(CMD_POP_BACK, 4'd4, '0, 4'd0));

    random_phase(settings[0], PHASE_ITEMS);
    // each new setting waits for every owed response first
    for (int i = 1; i < 8; i++) begin
      write_elem_bytes(settings[i]);
      random_phase(settings[i], PHASE_ITEMS);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
